/* hw/rtl/dcc_pkg.sv */
// ----------------------------------------------------------------------------
// Day-count convention package
// Widths, basis codes, reciprocal constants and the month-start table of the
// day-count convention unit.
// ----------------------------------------------------------------------------
package dcc_pkg;

    localparam int InW    = 41;
    localparam int DayW   = 26;
    localparam int RemW   = 18;
    localparam int NumStg = 17;
    localparam int NumDiv = 3;
    localparam int NumDate = 2;

    typedef enum logic [1:0] {
        BasisActual = 2'd0,
        BasisSia    = 2'd1,
        BasisEuro   = 2'd2
    } t_basis;

    // 675 * 12725830: lifts the 128-second quotient of any stamp above zero
    localparam logic [33:0] DayBias = 34'd8589935250;

    localparam int Div675      = 675;
    localparam int Recip675    = 25451658;   // floor(2^34 / 675)
    localparam int ZOffset     = 119689;     // 719468 + 83 eras - bias days
    localparam int DaysPerEra  = 146097;
    localparam int RecipEra    = 29398;      // floor(2^32 / 146097)
    localparam int CentDays    = 36524;
    localparam int Recip365    = 183860;     // ceil(2^26 / 365)
    localparam int DaysPerYear = 365;
    localparam int Recip153    = 6854;       // ceil(2^20 / 153)
    localparam int YearsPerEra = 400;
    localparam int DaysPerYr30 = 360;
    localparam int DaysPerMo30 = 30;

    // (153 * mp + 2) / 5 for a March-based month index
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] v;
        case (mp)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd31;
            4'd2:    v = 9'd61;
            4'd3:    v = 9'd92;
            4'd4:    v = 9'd122;
            4'd5:    v = 9'd153;
            4'd6:    v = 9'd184;
            4'd7:    v = 9'd214;
            4'd8:    v = 9'd245;
            4'd9:    v = 9'd275;
            4'd10:   v = 9'd306;
            4'd11:   v = 9'd337;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage

/* hw/rtl/day_count_convention_unit.sv */
// ----------------------------------------------------------------------------
// Day-count convention unit
// Day count between two epoch stamps under the actual, 30/360 SIA or
// 30/360 Eurobond basis, as a seventeen-stage pipeline.
// ----------------------------------------------------------------------------
// The unit takes one date pair per clock while o_stall is low; its stages
// follow the chain of constant-reciprocal multiply and correct steps
// (division by 86400, by the 400-year era, by 365 twice and by 153), each
// followed by a register. Results leave in the order the pairs came in. A
// stall on the output holds the last stage and the full stages right behind
// it; the rest keep filling, so o_stall rises only once every stage holds a
// word. For the actual basis (and the unused code three) day_count is the
// difference truncated toward zero and remainder_seconds carries the same
// sign; for the 30/360 bases remainder_seconds is zero.
module day_count_convention_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic signed [dcc_pkg::InW-1:0]    i_start_seconds,
    input  logic signed [dcc_pkg::InW-1:0]    i_end_seconds,
    input  logic        [1:0]                 i_basis,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [dcc_pkg::DayW-1:0]   o_day_count,
    output logic signed [dcc_pkg::RemW-1:0]   o_remainder_seconds
);
    import dcc_pkg::*;

    logic [NumStg:1] r_vld;
    logic [NumStg:1] en;

    logic [1:0]  r_basis [1:NumStg-1];
    logic        r_neg   [1:4];
    logic [6:0]  r_lo7   [1:4];
    logic [DayW-1:0] r_aday [5:NumStg-1];
    logic [RemW-1:0] r_arem [5:NumStg-1];

    // stage 1 to 4: divide by 675 on three lanes
    logic signed [41:0] n_s1_diff;
    logic [41:0] n_s1_mag;
    logic [34:0] n_s1_u    [NumDiv];
    logic [34:0] r_s1_u    [NumDiv];
    logic [57:0] n_s2_prod [NumDiv];
    logic [57:0] r_s2_prod [NumDiv];
    logic [34:0] r_s2_u    [NumDiv];
    logic [25:0] n_s3_q    [NumDiv];
    logic [34:0] n_s3_qm   [NumDiv];
    logic [25:0] r_s3_q    [NumDiv];
    logic [34:0] r_s3_qm   [NumDiv];
    logic [34:0] r_s3_u    [NumDiv];
    logic [34:0] n_s4_dr   [NumDiv];
    logic        n_s4_corr [NumDiv];
    logic [25:0] n_s4_q    [NumDiv];
    logic [9:0]  n_s4_rem;
    logic [25:0] r_s4_q    [NumDiv];
    logic [9:0]  r_s4_rem;

    // stage 5 onward: civil date on two lanes
    logic [DayW-1:0] n_s5_aday;
    logic [RemW-1:0] n_s5_arem;
    logic [16:0] n_s5_rmag;
    logic [39:0] n_s5_eprod  [NumDate];
    logic [39:0] r_s5_eprod  [NumDate];
    logic [24:0] r_s5_z      [NumDate];
    logic [7:0]  n_s6_era    [NumDate];
    logic [24:0] n_s6_em     [NumDate];
    logic [7:0]  r_s6_era    [NumDate];
    logic [24:0] r_s6_em     [NumDate];
    logic [24:0] r_s6_z      [NumDate];
    logic [24:0] n_s7_dr     [NumDate];
    logic        n_s7_corr   [NumDate];
    logic [17:0] n_s7_doe    [NumDate];
    logic [7:0]  n_s7_era    [NumDate];
    logic [17:0] r_s7_doe    [NumDate];
    logic [7:0]  r_s7_era    [NumDate];
    logic [35:0] n_s8_aprod  [NumDate];
    logic [2:0]  n_s8_b      [NumDate];
    logic        n_s8_c      [NumDate];
    logic [16:0] n_s8_ybase  [NumDate];
    logic [35:0] r_s8_aprod  [NumDate];
    logic [2:0]  r_s8_b      [NumDate];
    logic        r_s8_c      [NumDate];
    logic [16:0] r_s8_ybase  [NumDate];
    logic [17:0] r_s8_doe    [NumDate];
    logic [17:0] n_s9_x      [NumDate];
    logic [17:0] r_s9_x      [NumDate];
    logic [17:0] r_s9_doe    [NumDate];
    logic [16:0] r_s9_ybase  [NumDate];
    logic [35:0] n_s10_yprod [NumDate];
    logic [35:0] r_s10_yprod [NumDate];
    logic [17:0] r_s10_doe   [NumDate];
    logic [16:0] r_s10_ybase [NumDate];
    logic [8:0]  n_s11_yoe   [NumDate];
    logic [1:0]  n_s11_cent  [NumDate];
    logic [17:0] n_s11_t     [NumDate];
    logic [16:0] n_s11_year  [NumDate];
    logic [17:0] r_s11_t     [NumDate];
    logic [17:0] r_s11_doe   [NumDate];
    logic [16:0] r_s11_year  [NumDate];
    logic [8:0]  n_s12_doy   [NumDate];
    logic [10:0] n_s12_y5    [NumDate];
    logic [8:0]  r_s12_doy   [NumDate];
    logic [10:0] r_s12_y5    [NumDate];
    logic [16:0] r_s12_year  [NumDate];
    logic [23:0] n_s13_mprod [NumDate];
    logic [23:0] r_s13_mprod [NumDate];
    logic [8:0]  r_s13_doy   [NumDate];
    logic [16:0] r_s13_year  [NumDate];
    logic [3:0]  n_s14_mp    [NumDate];
    logic [4:0]  n_s14_day   [NumDate];
    logic [3:0]  n_s14_mon   [NumDate];
    logic [16:0] n_s14_year  [NumDate];
    logic [4:0]  r_s14_day   [NumDate];
    logic [3:0]  r_s14_mon   [NumDate];
    logic [16:0] r_s14_year  [NumDate];

    logic [4:0]  n_s15_d0;
    logic [4:0]  n_s15_d1;
    logic signed [17:0] n_s15_dy;
    logic signed [4:0]  n_s15_dm;
    logic signed [5:0]  n_s15_dd;
    logic signed [17:0] r_s15_dy;
    logic signed [4:0]  r_s15_dm;
    logic signed [5:0]  r_s15_dd;
    logic [DayW-1:0]    n_s16_p360;
    logic signed [9:0]  n_s16_rest;
    logic [DayW-1:0]    r_s16_p360;
    logic signed [9:0]  r_s16_rest;
    logic [DayW-1:0]    n_s17_days;
    logic [DayW-1:0]    n_s17_out;
    logic [RemW-1:0]    n_s17_rem;
    logic [DayW-1:0]    r_s17_days;
    logic [RemW-1:0]    r_s17_rem;

    // a stage loads when any stage at or after it is empty or the output drains
    for (genvar g = 1; g <= NumStg; g++) begin : g_en
        assign en[g] = !i_stall || !(&r_vld[NumStg:g]);
    end

    assign o_stall             = !en[1];
    assign o_valid             = r_vld[NumStg];
    assign o_day_count         = r_s17_days;
    assign o_remainder_seconds = r_s17_rem;

    always_comb begin
        n_s1_diff = 42'(i_end_seconds) - 42'(i_start_seconds);
        n_s1_mag  = n_s1_diff[41] ? 42'(-n_s1_diff) : 42'(n_s1_diff);
        n_s1_u[0] = n_s1_mag[41:7];
        n_s1_u[1] = 35'($signed(i_start_seconds[InW-1:7])) + 35'(DayBias);
        n_s1_u[2] = 35'($signed(i_end_seconds[InW-1:7])) + 35'(DayBias);

        n_s4_rem = '0;
        for (int l = 0; l < NumDiv; l++) begin
            n_s2_prod[l] = 58'(r_s1_u[l][34:2]) * 58'(Recip675);
            n_s3_q[l]    = r_s2_prod[l][57:32];
            n_s3_qm[l]   = 35'(n_s3_q[l]) * 35'(Div675);
            n_s4_dr[l]   = r_s3_u[l] - r_s3_qm[l];
            n_s4_corr[l] = n_s4_dr[l][10:0] >= 11'(Div675);
            n_s4_q[l]    = r_s3_q[l] + 26'(n_s4_corr[l])
                         + ((l == 0) ? 26'd0 : 26'(ZOffset));
        end
        n_s4_rem = n_s4_corr[0] ? 10'(n_s4_dr[0][10:0] - 11'(Div675)) : n_s4_dr[0][9:0];

        n_s5_rmag = {r_s4_rem, r_lo7[4]};
        n_s5_aday = r_neg[4] ? 26'd0 - r_s4_q[0] : r_s4_q[0];
        n_s5_arem = r_neg[4] ? 18'd0 - 18'(n_s5_rmag) : 18'(n_s5_rmag);

        for (int d = 0; d < NumDate; d++) begin
            n_s5_eprod[d] = 40'(r_s4_q[d+1][24:0]) * 40'(RecipEra);

            n_s6_era[d] = r_s5_eprod[d][39:32];
            n_s6_em[d]  = 25'(n_s6_era[d]) * 25'(DaysPerEra);

            n_s7_dr[d]   = r_s6_z[d] - r_s6_em[d];
            n_s7_corr[d] = n_s7_dr[d][18:0] >= 19'(DaysPerEra);
            n_s7_doe[d]  = n_s7_corr[d] ? 18'(n_s7_dr[d][18:0] - 19'(DaysPerEra))
                                        : n_s7_dr[d][17:0];
            n_s7_era[d]  = r_s6_era[d] + 8'(n_s7_corr[d]);

            n_s8_aprod[d] = 36'(r_s7_doe[d][17:2]) * 36'(Recip365);
            n_s8_b[d]     = 3'(r_s7_doe[d] >= 18'(CentDays))
                          + 3'(r_s7_doe[d] >= 18'(2 * CentDays))
                          + 3'(r_s7_doe[d] >= 18'(3 * CentDays))
                          + 3'(r_s7_doe[d] >= 18'(4 * CentDays));
            n_s8_c[d]     = r_s7_doe[d] == 18'(4 * CentDays);
            n_s8_ybase[d] = 17'(r_s7_era[d]) * 17'(YearsPerEra);

            n_s9_x[d] = r_s8_doe[d] - 18'(r_s8_aprod[d][35:26]) + 18'(r_s8_b[d])
                      - 18'(r_s8_c[d]);

            n_s10_yprod[d] = 36'(r_s9_x[d]) * 36'(Recip365);

            n_s11_yoe[d]  = r_s10_yprod[d][34:26];
            n_s11_cent[d] = 2'(n_s11_yoe[d] >= 9'd100) + 2'(n_s11_yoe[d] >= 9'd200)
                          + 2'(n_s11_yoe[d] >= 9'd300);
            n_s11_t[d]    = 18'(n_s11_yoe[d]) * 18'(DaysPerYear) + 18'(n_s11_yoe[d][8:2])
                          - 18'(n_s11_cent[d]);
            n_s11_year[d] = r_s10_ybase[d] + 17'(n_s11_yoe[d]);

            n_s12_doy[d] = 9'(r_s11_doe[d] - r_s11_t[d]);
            n_s12_y5[d]  = 11'({n_s12_doy[d], 2'b00}) + 11'(n_s12_doy[d]) + 11'd2;

            n_s13_mprod[d] = 24'(r_s12_y5[d]) * 24'(Recip153);

            n_s14_mp[d]   = r_s13_mprod[d][23:20];
            n_s14_day[d]  = 5'(r_s13_doy[d] - month_start(n_s14_mp[d]) + 9'd1);
            n_s14_mon[d]  = (n_s14_mp[d] >= 4'd10) ? n_s14_mp[d] - 4'd9 : n_s14_mp[d] + 4'd3;
            n_s14_year[d] = r_s13_year[d] + 17'(n_s14_mp[d] >= 4'd10);
        end

        n_s15_d0 = (r_s14_day[0] == 5'd31) ? 5'd30 : r_s14_day[0];
        case (r_basis[14])
            BasisEuro: n_s15_d1 = (r_s14_day[1] == 5'd31) ? 5'd30 : r_s14_day[1];
            BasisSia:  n_s15_d1 = (r_s14_day[1] == 5'd31 && n_s15_d0 == 5'd30)
                                ? 5'd30 : r_s14_day[1];
            default:   n_s15_d1 = r_s14_day[1];
        endcase
        n_s15_dy = $signed({1'b0, r_s14_year[1]}) - $signed({1'b0, r_s14_year[0]});
        n_s15_dm = $signed({1'b0, r_s14_mon[1]}) - $signed({1'b0, r_s14_mon[0]});
        n_s15_dd = $signed({1'b0, n_s15_d1}) - $signed({1'b0, n_s15_d0});

        n_s16_p360 = 26'(r_s15_dy) * 26'(DaysPerYr30);
        n_s16_rest = 10'(r_s15_dm) * 10'(DaysPerMo30) + 10'(r_s15_dd);

        n_s17_days = r_s16_p360 + 26'(r_s16_rest);
        case (r_basis[16])
            BasisSia, BasisEuro: begin
                n_s17_out = n_s17_days;
                n_s17_rem = '0;
            end
            default: begin
                n_s17_out = r_aday[16];
                n_s17_rem = r_arem[16];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[1]) begin
                r_vld[1] <= i_valid;
            end
            for (int k = 2; k <= NumStg; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_s1_u     <= n_s1_u;
            r_basis[1] <= i_basis;
            r_neg[1]   <= n_s1_diff[41];
            r_lo7[1]   <= n_s1_mag[6:0];
        end
        for (int k = 2; k < NumStg; k++) begin
            if (en[k]) begin
                r_basis[k] <= r_basis[k-1];
            end
        end
        for (int k = 2; k <= 4; k++) begin
            if (en[k]) begin
                r_neg[k] <= r_neg[k-1];
                r_lo7[k] <= r_lo7[k-1];
            end
        end
        if (en[2]) begin
            r_s2_prod <= n_s2_prod;
            r_s2_u    <= r_s1_u;
        end
        if (en[3]) begin
            r_s3_q  <= n_s3_q;
            r_s3_qm <= n_s3_qm;
            r_s3_u  <= r_s2_u;
        end
        if (en[4]) begin
            r_s4_q   <= n_s4_q;
            r_s4_rem <= n_s4_rem;
        end
        if (en[5]) begin
            r_aday[5]  <= n_s5_aday;
            r_arem[5]  <= n_s5_arem;
            r_s5_eprod <= n_s5_eprod;
            for (int d = 0; d < NumDate; d++) begin
                r_s5_z[d] <= r_s4_q[d+1][24:0];
            end
        end
        for (int k = 6; k < NumStg; k++) begin
            if (en[k]) begin
                r_aday[k] <= r_aday[k-1];
                r_arem[k] <= r_arem[k-1];
            end
        end
        if (en[6]) begin
            r_s6_era <= n_s6_era;
            r_s6_em  <= n_s6_em;
            r_s6_z   <= r_s5_z;
        end
        if (en[7]) begin
            r_s7_doe <= n_s7_doe;
            r_s7_era <= n_s7_era;
        end
        if (en[8]) begin
            r_s8_aprod <= n_s8_aprod;
            r_s8_b     <= n_s8_b;
            r_s8_c     <= n_s8_c;
            r_s8_ybase <= n_s8_ybase;
            r_s8_doe   <= r_s7_doe;
        end
        if (en[9]) begin
            r_s9_x     <= n_s9_x;
            r_s9_doe   <= r_s8_doe;
            r_s9_ybase <= r_s8_ybase;
        end
        if (en[10]) begin
            r_s10_yprod <= n_s10_yprod;
            r_s10_doe   <= r_s9_doe;
            r_s10_ybase <= r_s9_ybase;
        end
        if (en[11]) begin
            r_s11_t    <= n_s11_t;
            r_s11_doe  <= r_s10_doe;
            r_s11_year <= n_s11_year;
        end
        if (en[12]) begin
            r_s12_doy  <= n_s12_doy;
            r_s12_y5   <= n_s12_y5;
            r_s12_year <= r_s11_year;
        end
        if (en[13]) begin
            r_s13_mprod <= n_s13_mprod;
            r_s13_doy   <= r_s12_doy;
            r_s13_year  <= r_s12_year;
        end
        if (en[14]) begin
            r_s14_day  <= n_s14_day;
            r_s14_mon  <= n_s14_mon;
            r_s14_year <= n_s14_year;
        end
        if (en[15]) begin
            r_s15_dy <= n_s15_dy;
            r_s15_dm <= n_s15_dm;
            r_s15_dd <= n_s15_dd;
        end
        if (en[16]) begin
            r_s16_p360 <= n_s16_p360;
            r_s16_rest <= n_s16_rest;
        end
        if (en[17]) begin
            r_s17_days <= n_s17_out;
            r_s17_rem  <= n_s17_rem;
        end
    end

endmodule
